[rtl/svf_statement_lexer_defines.svh]
// ----------------------------------------------------------------------------
// SVF statement lexer assertion macros
// Shared concurrent assertion forms, clocked on clk with rst_n as disable.
// ----------------------------------------------------------------------------
`ifndef SVF_STATEMENT_LEXER_DEFINES_SVH
`define SVF_STATEMENT_LEXER_DEFINES_SVH

// Same-cycle implication.
`define SVF_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("svf_statement_lexer: same-cycle check failed");

// Next-cycle implication.
`define SVF_ASSERT_NXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("svf_statement_lexer: next-cycle check failed");

`endif

[rtl/svf_lex_pkg.sv]
// ----------------------------------------------------------------------------
// SVF lexer package
// Widths, character codes, result kinds and the structs shared by the lexer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package svf_lex_pkg;

    localparam int STMT_BYTES  = 4096;
    localparam int LEN_W       = $clog2(STMT_BYTES);
    localparam int CHAR_W      = 8;
    localparam int SLEN_W      = 12;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = QPTR_W + 1;

    typedef logic [CHAR_W-1:0] char_t;
    typedef logic [LEN_W-1:0]  len_t;

    typedef enum logic [1:0] {
        KIND_CHAR = 2'd0,
        KIND_END  = 2'd1,
        KIND_ERR  = 2'd2
    } kind_t;

    localparam char_t CH_BANG  = 8'h21;
    localparam char_t CH_SEMI  = 8'h3B;
    localparam char_t CH_SLASH = 8'h2F;
    localparam char_t CH_LF    = 8'h0A;
    localparam char_t CH_CR    = 8'h0D;
    localparam char_t CH_TAB   = 8'h09;
    localparam char_t CH_SPACE = 8'h20;

    typedef struct packed {
        kind_t              kind;
        char_t              char_out;
        logic [SLEN_W-1:0]  stmt_length;
        logic               last;
    } result_t;

    // Results of one lexing step: count is 0, 1 or 2.
    typedef struct packed {
        logic [1:0] count;
        result_t    res0;
        result_t    res1;
    } step_out_t;

    typedef struct packed {
        logic halted;
    } lex_status_t;

    typedef struct packed {
        logic [QCNT_W-1:0] fill;
        logic              room;
    } queue_status_t;

    function automatic result_t make_result(kind_t kind, char_t ch, logic [SLEN_W-1:0] len);
        result_t r;
        r.kind        = kind;
        r.char_out    = ch;
        r.stmt_length = len;
        r.last        = 1'b0;
        return r;
    endfunction

endpackage

[rtl/svf_lex_core.sv]
// ----------------------------------------------------------------------------
// SVF lexer core
// Lexer state and the single-pass step logic for one registered input word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module svf_lex_core (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     step,
    input  logic                     mode,
    input  svf_lex_pkg::char_t       byte_in,
    output svf_lex_pkg::step_out_t   results,
    output svf_lex_pkg::lex_status_t status
);
    import svf_lex_pkg::*;

    logic  skip_line_reg,     skip_line_next;
    char_t pending_char_reg,  pending_char_next;
    logic  pending_valid_reg, pending_valid_next;
    char_t earlier_char_reg,  earlier_char_next;
    len_t  length_count_reg,  length_count_next;
    logic  halted_reg,        halted_next;

    logic [LEN_W:0] total;
    char_t          lastc;
    char_t          c;
    logic           do_close;
    logic           is_eol;
    step_out_t      res;

    always_comb
    begin
        skip_line_next     = skip_line_reg;
        pending_char_next  = pending_char_reg;
        pending_valid_next = pending_valid_reg;
        earlier_char_next  = earlier_char_reg;
        length_count_next  = length_count_reg;
        halted_next        = halted_reg;
        res                = '0;
        do_close           = 1'b0;

        total  = {1'b0, length_count_reg} + {{LEN_W{1'b0}}, pending_valid_reg};
        lastc  = pending_valid_reg ? pending_char_reg : earlier_char_reg;
        is_eol = (byte_in == CH_LF) || (byte_in == CH_CR);
        c      = (is_eol || (byte_in == CH_TAB)) ? CH_SPACE : byte_in;

        if (step && !halted_reg)
        begin
            if (mode)
            begin
                do_close = 1'b1;
            end
            else if (skip_line_reg)
            begin
                if (is_eol)
                begin
                    skip_line_next = 1'b0;
                end
            end
            else if (byte_in == CH_BANG)
            begin
                skip_line_next = 1'b1;
            end
            else if ((byte_in == CH_SLASH) && pending_valid_reg && (pending_char_reg == CH_SLASH))
            begin
                // take back the held slash and open a comment
                pending_valid_next = 1'b0;
                pending_char_next  = '0;
                skip_line_next     = 1'b1;
            end
            else if (byte_in == CH_SEMI)
            begin
                do_close = 1'b1;
            end
            else if ((c == CH_SPACE) && ((total == '0) || (lastc == CH_SPACE)))
            begin
                // drop leading and repeated spaces
            end
            else if (total >= (LEN_W+1)'(STMT_BYTES - 1))
            begin
                halted_next = 1'b1;
                res.count   = 2'd1;
                res.res0    = make_result(KIND_ERR, '0, '0);
            end
            else
            begin
                if (pending_valid_reg)
                begin
                    res.count         = 2'd1;
                    res.res0          = make_result(KIND_CHAR, pending_char_reg, '0);
                    earlier_char_next = pending_char_reg;
                    length_count_next = length_count_reg + len_t'(1);
                end
                pending_char_next  = c;
                pending_valid_next = 1'b1;
            end
        end

        if (do_close)
        begin
            if (total != '0)
            begin
                if (pending_valid_reg)
                begin
                    res.count = 2'd2;
                    res.res0  = make_result(KIND_CHAR, pending_char_reg, '0);
                    res.res1  = make_result(KIND_END, '0, SLEN_W'(total));
                end
                else
                begin
                    res.count = 2'd1;
                    res.res0  = make_result(KIND_END, '0, SLEN_W'(total));
                end
            end
            pending_valid_next = 1'b0;
            pending_char_next  = '0;
            earlier_char_next  = '0;
            length_count_next  = '0;
        end

        // mark the final result of this word
        if (res.count == 2'd2)
        begin
            res.res1.last = 1'b1;
        end
        else if (res.count == 2'd1)
        begin
            res.res0.last = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skip_line_reg     <= 1'b0;
            pending_char_reg  <= '0;
            pending_valid_reg <= 1'b0;
            earlier_char_reg  <= '0;
            length_count_reg  <= '0;
            halted_reg        <= 1'b0;
        end
        else
        begin
            skip_line_reg     <= skip_line_next;
            pending_char_reg  <= pending_char_next;
            pending_valid_reg <= pending_valid_next;
            earlier_char_reg  <= earlier_char_next;
            length_count_reg  <= length_count_next;
            halted_reg        <= halted_next;
        end
    end

    assign results       = res;
    assign status.halted = halted_reg;

endmodule

[rtl/svf_lex_queue.sv]
// ----------------------------------------------------------------------------
// SVF lexer result queue
// Small register queue taking up to two results a cycle, draining one on pop.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module svf_lex_queue (
    input  logic                       clk,
    input  logic                       rst_n,
    input  svf_lex_pkg::step_out_t     push,
    input  logic                       pop,
    output svf_lex_pkg::result_t       head,
    output logic                       head_valid,
    output svf_lex_pkg::queue_status_t status
);
    import svf_lex_pkg::*;

    result_t             entries_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   head_reg, head_next;
    logic [QCNT_W-1:0]   fill_reg, fill_next;
    logic [QPTR_W-1:0]   tail0;
    logic [QPTR_W-1:0]   tail1;
    logic                do_pop;

    assign head_valid = (fill_reg != '0);
    assign do_pop     = pop && head_valid;
    assign tail0      = head_reg + fill_reg[QPTR_W-1:0];
    assign tail1      = tail0 + QPTR_W'(1);

    always_comb
    begin
        head_next = do_pop ? head_reg + QPTR_W'(1) : head_reg;
        fill_next = fill_reg + QCNT_W'(push.count) - QCNT_W'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            fill_reg <= '0;
        end
        else
        begin
            head_reg <= head_next;
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            entries_reg[tail0] <= push.res0;
        end
        if (push.count == 2'd2)
        begin
            entries_reg[tail1] <= push.res1;
        end
    end

    assign head        = entries_reg[head_reg];
    assign status.fill = fill_reg;
    // keep room for a two-result word
    assign status.room = (fill_reg <= QCNT_W'(QUEUE_DEPTH - 2));

endmodule

[rtl/svf_statement_lexer.sv]
// ----------------------------------------------------------------------------
// SVF statement lexer
// Byte-stream front end that turns raw SVF text into normalised statements.
// ----------------------------------------------------------------------------
// Takes one word per cycle on the slave side: a text byte, or an end-of-input
// marker (tuser high). Comments opened by '!' or '//' are dropped to the end
// of the line, CR, LF and tab become spaces, and leading or repeated spaces
// are squeezed out. Each character is held back one place so a first '/' can
// be withdrawn. A ';' or end of input closes the statement: the held
// character comes out, then an end-of-statement word carrying the length;
// an empty statement emits nothing. A statement overflowing its capacity
// gives a single error word and the block then swallows all input until
// reset. One input word is taken per cycle while the queue has room; an
// accepted word passes the input register and the result queue before its
// first result. A word can raise two results; the four-entry queue drains
// one per cycle while m_tready is high; input stalls only if it holds more than two.
`timescale 1ns / 1ps

`include "svf_statement_lexer_defines.svh"

module svf_statement_lexer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] byte_in
    input  logic [0:0]  s_tuser,   // [0] mode (1 = end of input)
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [7:0] char_out, [19:8] stmt_length, [23:20] zero
    output logic [1:0]  m_tuser,   // [1:0] kind
    output logic        m_tlast    // final result of its input word
);
    import svf_lex_pkg::*;

    // input register
    logic          in_valid_reg;
    logic          in_mode_reg;
    char_t         in_byte_reg;
    logic          step;

    step_out_t     step_res;
    lex_status_t   lex_stat;
    result_t       q_head;
    logic          q_head_valid;
    queue_status_t q_stat;

    // advance the held word only when the queue can take both its results
    assign step     = in_valid_reg && q_stat.room;
    assign s_tready = !in_valid_reg || step;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    // payload: hold while stalled
    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_mode_reg <= s_tuser[0];
            in_byte_reg <= s_tdata;
        end
    end

    svf_lex_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .mode    (in_mode_reg),
        .byte_in (in_byte_reg),
        .results (step_res),
        .status  (lex_stat)
    );

    svf_lex_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (step_res),
        .pop        (m_tready),
        .head       (q_head),
        .head_valid (q_head_valid),
        .status     (q_stat)
    );

    assign m_tvalid = q_head_valid;
    assign m_tdata  = {4'b0000, q_head.stmt_length, q_head.char_out};
    assign m_tuser  = q_head.kind;
    assign m_tlast  = q_head.last;

    // Checks on the lexer's own logic.
    `SVF_ASSERT_IMP(a_no_output_when_halted, lex_stat.halted, step_res.count == 2'd0)
    `SVF_ASSERT_IMP(a_queue_never_overfills, 1'b1, q_stat.fill <= QCNT_W'(QUEUE_DEPTH))
    `SVF_ASSERT_IMP(a_pair_ends_statement, step_res.count == 2'd2, (step_res.res1.kind == KIND_END) && step_res.res1.last && !step_res.res0.last)
    `SVF_ASSERT_NXT(a_error_halts, (step_res.count != 2'd0) && (step_res.res0.kind == KIND_ERR), lex_stat.halted)

endmodule
